// ===== rtl/core/rtdf_pkg.sv =====
// Shared types, codes and constants for the raw transaction deframer.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package rtdf_pkg;

    // Fixed txid size in bytes and default width of the script length counter
    localparam int TXID_BYTES           = 32;
    localparam int SCRIPT_LEN_BITS_DEF  = 32;

    // Compact-size markers and their extension widths
    localparam logic [7:0] CS_MARK16 = 8'hFD;
    localparam logic [7:0] CS_MARK32 = 8'hFE;
    localparam logic [3:0] CS_W_NONE = 4'd0;
    localparam logic [3:0] CS_W2     = 4'd2;
    localparam logic [3:0] CS_W4     = 4'd4;
    localparam logic [3:0] CS_W8     = 4'd8;

    // Field kind codes reported with every beat
    localparam logic [3:0] KIND_PREFIX   = 4'd0;
    localparam logic [3:0] KIND_VERSION  = 4'd1;
    localparam logic [3:0] KIND_INCOUNT  = 4'd2;
    localparam logic [3:0] KIND_TXID     = 4'd3;
    localparam logic [3:0] KIND_VOUT     = 4'd4;
    localparam logic [3:0] KIND_SIGLEN   = 4'd5;
    localparam logic [3:0] KIND_SIG      = 4'd6;
    localparam logic [3:0] KIND_SEQ      = 4'd7;
    localparam logic [3:0] KIND_OUTCOUNT = 4'd8;
    localparam logic [3:0] KIND_AMOUNT   = 4'd9;
    localparam logic [3:0] KIND_PKLEN    = 4'd10;
    localparam logic [3:0] KIND_PK       = 4'd11;
    localparam logic [3:0] KIND_LOCKTIME = 4'd12;
    localparam logic [3:0] KIND_IDLE     = 4'd13;

    // Parser phase, one-hot
    typedef enum logic [13:0] {
        PH_PREFIX   = 14'b00000000000001,
        PH_VERSION  = 14'b00000000000010,
        PH_INCOUNT  = 14'b00000000000100,
        PH_TXID     = 14'b00000000001000,
        PH_VOUT     = 14'b00000000010000,
        PH_SIGLEN   = 14'b00000000100000,
        PH_SIG      = 14'b00000001000000,
        PH_SEQ      = 14'b00000010000000,
        PH_OUTCOUNT = 14'b00000100000000,
        PH_AMOUNT   = 14'b00001000000000,
        PH_PKLEN    = 14'b00010000000000,
        PH_PK       = 14'b00100000000000,
        PH_LOCKTIME = 14'b01000000000000,
        PH_IDLE     = 14'b10000000000000
    } rtdf_phase_t;

    // One result beat
    typedef struct packed {
        logic        hash_valid;
        logic [7:0]  hash_byte;
        logic [3:0]  field_kind;
        logic        value_valid;
        logic [63:0] field_value;
        logic [7:0]  input_index;
        logic [7:0]  output_index;
        logic [7:0]  input_total;
        logic [7:0]  output_total;
        logic        tx_done;
        logic        parse_error;
    } rtdf_result_t;

    // Map a phase to its reported field kind
    function automatic logic [3:0] phase_kind(input rtdf_phase_t ph);
        logic [3:0] k;
        case (ph)
            PH_PREFIX:   k = KIND_PREFIX;
            PH_VERSION:  k = KIND_VERSION;
            PH_INCOUNT:  k = KIND_INCOUNT;
            PH_TXID:     k = KIND_TXID;
            PH_VOUT:     k = KIND_VOUT;
            PH_SIGLEN:   k = KIND_SIGLEN;
            PH_SIG:      k = KIND_SIG;
            PH_SEQ:      k = KIND_SEQ;
            PH_OUTCOUNT: k = KIND_OUTCOUNT;
            PH_AMOUNT:   k = KIND_AMOUNT;
            PH_PKLEN:    k = KIND_PKLEN;
            PH_PK:       k = KIND_PK;
            PH_LOCKTIME: k = KIND_LOCKTIME;
            default:     k = KIND_IDLE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtdf_fsm.sv =====
// Parser state registers and the single-pass next-state / result logic.
// Depends on rtdf_pkg for phase type, codes and the result struct.
`default_nettype none

module rtdf_fsm #(
    parameter int SCRIPT_LEN_BITS = rtdf_pkg::SCRIPT_LEN_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 restart,
    output rtdf_pkg::rtdf_result_t    result
);

    rtdf_pkg::rtdf_phase_t        phase_reg, phase_next;
    logic [3:0]                   cnt_reg, cnt_next;
    logic [3:0]                   vw_reg, vw_next;
    logic [63:0]                  acc_reg, acc_next;
    logic [SCRIPT_LEN_BITS-1:0]   rem_reg, rem_next;
    logic [7:0]                   iseen_reg, iseen_next;
    logic [7:0]                   oseen_reg, oseen_next;
    logic [7:0]                   iexp_reg, iexp_next;
    logic [7:0]                   oexp_reg, oexp_next;
    logic                         err_reg, err_next;

    // Working view of the state, with restart folded in
    rtdf_pkg::rtdf_phase_t        ph;
    logic [3:0]                   cnt, vw;
    logic [63:0]                  acc, lane;
    logic [SCRIPT_LEN_BITS-1:0]   rem;
    logic [7:0]                   iseen, oseen, iexp, oexp;
    logic                         err;

    rtdf_pkg::rtdf_phase_t        go_ph;
    logic                         fresh;
    logic                         hv, vv, done, bad, len_done;
    logic [63:0]                  val, len_val;
    logic [3:0]                   kind;

    always_comb
    begin
        // Start from reset values when this beat restarts the parse
        ph    = restart ? rtdf_pkg::PH_PREFIX : phase_reg;
        cnt   = restart ? 4'd0 : cnt_reg;
        vw    = restart ? rtdf_pkg::CS_W_NONE : vw_reg;
        acc   = restart ? 64'd0 : acc_reg;
        rem   = restart ? '0 : rem_reg;
        iseen = restart ? 8'd0 : iseen_reg;
        oseen = restart ? 8'd0 : oseen_reg;
        iexp  = restart ? 8'd0 : iexp_reg;
        oexp  = restart ? 8'd0 : oexp_reg;
        err   = restart ? 1'b0 : err_reg;

        kind = rtdf_pkg::phase_kind(ph);
        lane = acc | ({56'd0, data_byte} << {cnt[2:0], 3'b000});

        phase_next = ph;
        cnt_next   = cnt;
        vw_next    = vw;
        acc_next   = acc;
        rem_next   = rem;
        iseen_next = iseen;
        oseen_next = oseen;
        iexp_next  = iexp;
        oexp_next  = oexp;
        err_next   = err;

        go_ph    = ph;
        fresh    = 1'b0;
        hv       = 1'b0;
        vv       = 1'b0;
        done     = 1'b0;
        bad      = 1'b0;
        val      = 64'd0;
        len_done = 1'b0;
        len_val  = 64'd0;

        case (ph)
            rtdf_pkg::PH_PREFIX:
            begin
                if (data_byte != 8'd0)
                    bad = 1'b1;
                else
                begin
                    go_ph = rtdf_pkg::PH_VERSION;
                    fresh = 1'b1;
                end
            end

            rtdf_pkg::PH_VERSION, rtdf_pkg::PH_VOUT:
            begin
                hv       = 1'b1;
                cnt_next = cnt + 4'd1;
                if (cnt == 4'd3)
                begin
                    go_ph = (ph == rtdf_pkg::PH_VERSION) ? rtdf_pkg::PH_INCOUNT
                                                         : rtdf_pkg::PH_SIGLEN;
                    fresh = 1'b1;
                end
            end

            rtdf_pkg::PH_INCOUNT:
            begin
                hv         = 1'b1;
                iexp_next  = data_byte;
                iseen_next = 8'd0;
                fresh      = 1'b1;
                if (data_byte == 8'd0)
                    go_ph = rtdf_pkg::PH_OUTCOUNT;
                else
                begin
                    go_ph    = rtdf_pkg::PH_TXID;
                    rem_next = SCRIPT_LEN_BITS'(rtdf_pkg::TXID_BYTES);
                end
            end

            rtdf_pkg::PH_TXID, rtdf_pkg::PH_SIG:
            begin
                hv       = 1'b1;
                rem_next = rem - SCRIPT_LEN_BITS'(1);
                if (rem_next == '0)
                begin
                    go_ph = (ph == rtdf_pkg::PH_TXID) ? rtdf_pkg::PH_VOUT
                                                      : rtdf_pkg::PH_SEQ;
                    fresh = 1'b1;
                end
            end

            rtdf_pkg::PH_SIGLEN, rtdf_pkg::PH_PKLEN:
            begin
                // Compact-size length: byte < FD, or marker then 2, 4 or 8 bytes
                if (vw == rtdf_pkg::CS_W_NONE)
                begin
                    if (data_byte < rtdf_pkg::CS_MARK16)
                    begin
                        len_done = 1'b1;
                        len_val  = {56'd0, data_byte};
                    end
                    else
                    begin
                        vw_next  = (data_byte == rtdf_pkg::CS_MARK16) ? rtdf_pkg::CS_W2 :
                                   (data_byte == rtdf_pkg::CS_MARK32) ? rtdf_pkg::CS_W4 :
                                                                        rtdf_pkg::CS_W8;
                        cnt_next = 4'd0;
                        acc_next = 64'd0;
                    end
                end
                else
                begin
                    acc_next = lane;
                    cnt_next = cnt + 4'd1;
                    if (cnt_next == vw)
                    begin
                        // Reject non-canonical or oversized lengths
                        if ((vw == rtdf_pkg::CS_W2 && lane < 64'h0000_00FD) ||
                            (vw == rtdf_pkg::CS_W4 && lane <= 64'h0000_FFFF) ||
                            (vw == rtdf_pkg::CS_W8 && lane <= 64'hFFFF_FFFF) ||
                            (|lane[63:SCRIPT_LEN_BITS]))
                            bad = 1'b1;
                        else
                        begin
                            len_done = 1'b1;
                            len_val  = lane;
                        end
                    end
                end

                if (!bad)
                    hv = 1'b1;

                if (len_done)
                begin
                    vv       = 1'b1;
                    val      = len_val;
                    rem_next = len_val[SCRIPT_LEN_BITS-1:0];
                    fresh    = 1'b1;
                    if (len_val[SCRIPT_LEN_BITS-1:0] == '0)
                    begin
                        if (ph == rtdf_pkg::PH_SIGLEN)
                            go_ph = rtdf_pkg::PH_SEQ;
                        else
                        begin
                            oseen_next = oseen + 8'd1;
                            go_ph = (oseen_next == oexp) ? rtdf_pkg::PH_LOCKTIME
                                                         : rtdf_pkg::PH_AMOUNT;
                        end
                    end
                    else
                        go_ph = (ph == rtdf_pkg::PH_SIGLEN) ? rtdf_pkg::PH_SIG
                                                            : rtdf_pkg::PH_PK;
                end
            end

            rtdf_pkg::PH_SEQ:
            begin
                hv       = 1'b1;
                cnt_next = cnt + 4'd1;
                if (cnt == 4'd3)
                begin
                    // Close the input; start the next one or the output count
                    iseen_next = iseen + 8'd1;
                    fresh      = 1'b1;
                    if (iseen_next == iexp)
                        go_ph = rtdf_pkg::PH_OUTCOUNT;
                    else
                    begin
                        go_ph    = rtdf_pkg::PH_TXID;
                        rem_next = SCRIPT_LEN_BITS'(rtdf_pkg::TXID_BYTES);
                    end
                end
            end

            rtdf_pkg::PH_OUTCOUNT:
            begin
                hv         = 1'b1;
                oexp_next  = data_byte;
                oseen_next = 8'd0;
                fresh      = 1'b1;
                go_ph = (data_byte == 8'd0) ? rtdf_pkg::PH_LOCKTIME
                                            : rtdf_pkg::PH_AMOUNT;
            end

            rtdf_pkg::PH_AMOUNT:
            begin
                hv       = 1'b1;
                acc_next = lane;
                cnt_next = cnt + 4'd1;
                if (cnt == 4'd7)
                begin
                    vv    = 1'b1;
                    val   = lane;
                    go_ph = rtdf_pkg::PH_PKLEN;
                    fresh = 1'b1;
                end
            end

            rtdf_pkg::PH_PK:
            begin
                hv       = 1'b1;
                rem_next = rem - SCRIPT_LEN_BITS'(1);
                if (rem_next == '0)
                begin
                    oseen_next = oseen + 8'd1;
                    fresh      = 1'b1;
                    go_ph = (oseen_next == oexp) ? rtdf_pkg::PH_LOCKTIME
                                                 : rtdf_pkg::PH_AMOUNT;
                end
            end

            rtdf_pkg::PH_LOCKTIME:
            begin
                hv       = 1'b1;
                acc_next = lane;
                cnt_next = cnt + 4'd1;
                if (cnt == 4'd3)
                begin
                    vv    = 1'b1;
                    val   = lane;
                    done  = 1'b1;
                    go_ph = rtdf_pkg::PH_IDLE;
                    fresh = 1'b1;
                end
            end

            default:
            begin
                kind  = rtdf_pkg::KIND_IDLE;
                go_ph = rtdf_pkg::PH_IDLE;
            end
        endcase

        // Suppress hash and value on the erroring beat and park until restart
        if (bad)
        begin
            err_next = 1'b1;
            hv       = 1'b0;
            vv       = 1'b0;
            val      = 64'd0;
            go_ph    = rtdf_pkg::PH_IDLE;
            fresh    = 1'b1;
        end

        phase_next = go_ph;
        if (fresh)
        begin
            cnt_next = 4'd0;
            vw_next  = rtdf_pkg::CS_W_NONE;
            acc_next = 64'd0;
        end

        result.hash_valid   = hv;
        result.hash_byte    = data_byte;
        result.field_kind   = kind;
        result.value_valid  = vv;
        result.field_value  = val;
        result.input_index  = iseen_next;
        result.output_index = oseen_next;
        result.input_total  = iexp_next;
        result.output_total = oexp_next;
        result.tx_done      = done;
        result.parse_error  = err_next;
    end

    // Advance the parser state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rtdf_pkg::PH_PREFIX;
            cnt_reg   <= 4'd0;
            vw_reg    <= rtdf_pkg::CS_W_NONE;
            acc_reg   <= 64'd0;
            rem_reg   <= '0;
            iseen_reg <= 8'd0;
            oseen_reg <= 8'd0;
            iexp_reg  <= 8'd0;
            oexp_reg  <= 8'd0;
            err_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            vw_reg    <= vw_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            iseen_reg <= iseen_next;
            oseen_reg <= oseen_next;
            iexp_reg  <= iexp_next;
            oexp_reg  <= oexp_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rtdf_out_reg.sv =====
// Result register with valid/stall handshake toward the consumer.
// Depends on rtdf_pkg for the result struct.
`default_nettype none

module rtdf_out_reg (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire rtdf_pkg::rtdf_result_t  result_in,
    input  wire logic                    out_stall,
    output logic                         out_valid,
    output rtdf_pkg::rtdf_result_t       result_out
);

    logic                    valid_reg, valid_next;
    rtdf_pkg::rtdf_result_t  data_reg;

    // Hold while stalled, drop once taken, refill on a new beat
    assign valid_next = load | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload carries no reset
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/raw_transaction_deframer_unit.sv =====
// Top level of the raw transaction deframer: parser plus result register.
// Depends on rtdf_pkg, rtdf_fsm and rtdf_out_reg.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  data_byte, restart
//   out      source     out_valid/out_stall  hash_valid .. parse_error (11 fields)
//
// One beat in, one beat out. A byte is parsed in the cycle it is accepted and
// its result appears registered on the next cycle; throughput one byte per cycle
// while in_stall is low, with a single parser state update per beat.
// Reset clears the parser to expect the prefix byte and empties the result
// register. in_stall rises only while a result is held and out_stall is high;
// the result register refills in the same cycle it is drained.
`default_nettype none

module raw_transaction_deframer_unit #(
    parameter int SCRIPT_LEN_BITS = rtdf_pkg::SCRIPT_LEN_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        restart,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hash_valid,
    output logic [7:0]       hash_byte,
    output logic [3:0]       field_kind,
    output logic             value_valid,
    output logic [63:0]      field_value,
    output logic [7:0]       input_index,
    output logic [7:0]       output_index,
    output logic [7:0]       input_total,
    output logic [7:0]       output_total,
    output logic             tx_done,
    output logic             parse_error
);

    logic                    take;
    rtdf_pkg::rtdf_result_t  beat_result;
    rtdf_pkg::rtdf_result_t  held_result;

    // Accept a beat whenever the result register is free or being drained
    assign in_stall = out_valid & out_stall;
    assign take     = in_valid & ~in_stall;

    rtdf_fsm #(
        .SCRIPT_LEN_BITS (SCRIPT_LEN_BITS)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .restart   (restart),
        .result    (beat_result)
    );

    rtdf_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .result_in  (beat_result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .result_out (held_result)
    );

    // Unpack the held result onto the ports
    assign hash_valid   = held_result.hash_valid;
    assign hash_byte    = held_result.hash_byte;
    assign field_kind   = held_result.field_kind;
    assign value_valid  = held_result.value_valid;
    assign field_value  = held_result.field_value;
    assign input_index  = held_result.input_index;
    assign output_index = held_result.output_index;
    assign input_total  = held_result.input_total;
    assign output_total = held_result.output_total;
    assign tx_done      = held_result.tx_done;
    assign parse_error  = held_result.parse_error;

endmodule

`default_nettype wire
